// ===== hdl/cram_palette_to_rgb_macros.svh =====
// ---------------------------------------------------------------------------
// cram palette assertion macros
// concurrent assertion wrappers, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef CRAM_PALETTE_TO_RGB_MACROS_SVH
`define CRAM_PALETTE_TO_RGB_MACROS_SVH

`ifndef SYNTH

// clocked assertion, disabled while reset is asserted
`define CPR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define CPR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CPR_ASSERT(lbl, clk, rst_n, prop, msg)
`define CPR_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/cpr_pkg.sv =====
// ---------------------------------------------------------------------------
// cram palette package
// shared types, constants and shading function
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cpr_pkg;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned ENTRY_W     = 6;
  localparam int unsigned STORE_W     = 9;
  localparam int unsigned COLOUR_W    = 16;
  localparam int unsigned FIELD_W     = 5;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned APB_AW      = 4;
  localparam int unsigned APB_DW      = 32;

  localparam logic [POS_W-1:0] RED_POS_RST   = 4'd10;
  localparam logic [POS_W-1:0] GREEN_POS_RST = 4'd5;
  localparam logic [POS_W-1:0] BLUE_POS_RST  = 4'd0;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_RED   = 2'd0;
  localparam logic [1:0] REG_GREEN = 2'd1;
  localparam logic [1:0] REG_BLUE  = 2'd2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_PIXEL = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_HIGHLIGHT = 2'd1,
    MODE_SHADOW    = 2'd2,
    MODE_BAD       = 2'd3
  } mode_e;

  typedef struct packed {
    logic [POS_W-1:0] red_pos;
    logic [POS_W-1:0] green_pos;
    logic [POS_W-1:0] blue_pos;
  } cfg_t;

  // 3-bit component to 5-bit shaded level
  function automatic logic [FIELD_W-1:0] shade(input logic [2:0] c, input mode_e mode);
    logic [FIELD_W-1:0] f;
    case (mode)
      MODE_NORMAL:    f = {c, 2'b00};
      MODE_HIGHLIGHT: f = {1'b1, c, 1'b0};
      MODE_SHADOW:    f = {1'b0, c, 1'b0};
      default:        f = '0;
    endcase
    return f;
  endfunction

endpackage

// ===== hdl/cpr_in_if.sv =====
// ---------------------------------------------------------------------------
// cram palette input channel
// valid/ready channel carrying write and pixel items
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cpr_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [5:0]  entry_number;
  logic [15:0] colour_word;
  logic [7:0]  pixel_index;
  logic        line_last;

  modport source (output valid, opcode, entry_number, colour_word, pixel_index, line_last,
                  input ready);
  modport sink   (input valid, opcode, entry_number, colour_word, pixel_index, line_last,
                  output ready);
endinterface

// ===== hdl/cpr_out_if.sv =====
// ---------------------------------------------------------------------------
// cram palette output channel
// valid/ready channel carrying packed pixel colours
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cpr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_colour;
  logic        bad_index;
  logic        line_last_out;

  modport source (output valid, pixel_colour, bad_index, line_last_out, input ready);
  modport sink   (input valid, pixel_colour, bad_index, line_last_out, output ready);
endinterface

// ===== hdl/cpr_regs.sv =====
// ---------------------------------------------------------------------------
// cram palette register file
// apb-style position registers for the three colour fields
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpr_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic [cpr_pkg::APB_AW-1:0] paddr_i,
  input  logic [cpr_pkg::APB_DW-1:0] pwdata_i,
  output logic [cpr_pkg::APB_DW-1:0] prdata_o,
  output logic                      pready_o,
  output cpr_pkg::cfg_t             cfg_o
);
  import cpr_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready_o = 1'b1;
  assign reg_idx  = paddr_i[APB_AW-1:2];
  assign wr_en    = psel_i & penable_i & pwrite_i;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_RED:   cfg_d.red_pos   = pwdata_i[POS_W-1:0];
        REG_GREEN: cfg_d.green_pos = pwdata_i[POS_W-1:0];
        REG_BLUE:  cfg_d.blue_pos  = pwdata_i[POS_W-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_pos   <= RED_POS_RST;
      cfg_q.green_pos <= GREEN_POS_RST;
      cfg_q.blue_pos  <= BLUE_POS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RED:   prdata_o = APB_DW'(cfg_q.red_pos);
      REG_GREEN: prdata_o = APB_DW'(cfg_q.green_pos);
      REG_BLUE:  prdata_o = APB_DW'(cfg_q.blue_pos);
      default:   prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/cpr_store.sv =====
// ---------------------------------------------------------------------------
// cram palette colour store
// 64 x 9 colour memory with registered read and per-entry valid bits
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpr_store (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [cpr_pkg::ENTRY_W-1:0] wr_addr_i,
  input  logic [cpr_pkg::STORE_W-1:0] wr_data_i,
  input  logic                        rd_en_i,
  input  logic [cpr_pkg::ENTRY_W-1:0] rd_addr_i,
  output logic [cpr_pkg::STORE_W-1:0] rd_data_o
);
  import cpr_pkg::*;

  logic [STORE_W-1:0]     mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] vld_q;
  logic [STORE_W-1:0]     rd_q;
  logic                   rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

// ===== hdl/cpr_shade.sv =====
// ---------------------------------------------------------------------------
// cram palette shader
// shades one store entry and packs the fields into a 16-bit colour
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cpr_shade (
  input  cpr_pkg::cfg_t                cfg_i,
  input  logic [cpr_pkg::STORE_W-1:0]  entry_i,
  input  cpr_pkg::mode_e               mode_i,
  output logic [cpr_pkg::COLOUR_W-1:0] colour_o,
  output logic                         bad_o
);
  import cpr_pkg::*;

  logic [COLOUR_W-1:0] red_f, green_f, blue_f;

  // fields pushed past bit 15 fall off the top
  assign red_f   = COLOUR_W'(shade(entry_i[2:0], mode_i)) << cfg_i.red_pos;
  assign green_f = COLOUR_W'(shade(entry_i[5:3], mode_i)) << cfg_i.green_pos;
  assign blue_f  = COLOUR_W'(shade(entry_i[8:6], mode_i)) << cfg_i.blue_pos;

  assign bad_o    = (mode_i == MODE_BAD);
  assign colour_o = bad_o ? '0 : (red_f | green_f | blue_f);

endmodule

// ===== hdl/cram_palette_to_rgb.sv =====
// ---------------------------------------------------------------------------
// cram palette to rgb
// 64-entry console palette with normal, highlight and shadow shading
// ---------------------------------------------------------------------------
// One item per clock in while the output does not stall, one result per
// pixel item out: the colour store read is registered first (the single
// memory read port), then the shaded and packed colour is registered.
// Write items update the store and produce no result; a
// pixel item right behind a write to the same entry already sees the new
// colour. Store entries read as zero until written (per-entry valid bits
// cleared by reset, so no clearing pass is needed). Pixel modes: 0 normal
// (4c), 1 highlight (16+2c), 2 shadow (2c); mode 3 sets bad_index and
// gives a zero colour. Field positions come from three apb registers at
// byte addresses 0 (red), 4 (green) and 8 (blue) and should only be
// changed while no pixels are in flight. The whole pipe stalls while a
// result waits on the output.
`timescale 1ns / 1ps

`include "cram_palette_to_rgb_macros.svh"

module cram_palette_to_rgb (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  cpr_in_if.sink                     pix_i,
  cpr_out_if.source                  res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cpr_pkg::APB_AW-1:0] paddr,
  input  logic [cpr_pkg::APB_DW-1:0] pwdata,
  output logic [cpr_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import cpr_pkg::*;

  cfg_t cfg;

  // pipe control
  logic adv;
  logic in_acc;
  logic is_pixel;

  // read stage
  logic        s1_vld_q, s1_vld_d;
  mode_e       s1_mode_q;
  logic        s1_last_q;
  logic [STORE_W-1:0] s1_entry;

  // result stage
  logic                out_vld_q, out_vld_d;
  logic [COLOUR_W-1:0] out_colour_q;
  logic                out_bad_q;
  logic                out_last_q;
  logic [COLOUR_W-1:0] shade_colour;
  logic                shade_bad;

  cpr_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // everything moves unless a finished result is held on the output
  assign adv         = !out_vld_q || res_o.ready;
  assign pix_i.ready = adv;
  assign in_acc      = pix_i.valid && adv;
  assign is_pixel    = (pix_i.opcode == OP_PIXEL);

  // console word 0000BBB0GGG0RRR0 packs to {b, g, r}
  cpr_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_acc && !is_pixel),
    .wr_addr_i (pix_i.entry_number),
    .wr_data_i ({pix_i.colour_word[11:9], pix_i.colour_word[7:5], pix_i.colour_word[3:1]}),
    .rd_en_i   (in_acc && is_pixel),
    .rd_addr_i (pix_i.pixel_index[ENTRY_W-1:0]),
    .rd_data_o (s1_entry)
  );

  assign s1_vld_d  = adv ? (in_acc && is_pixel) : s1_vld_q;
  assign out_vld_d = adv ? s1_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers hold across stalls
  always_ff @(posedge clk_i) begin
    if (in_acc && is_pixel) begin
      s1_mode_q <= mode_e'(pix_i.pixel_index[7:6]);
      s1_last_q <= pix_i.line_last;
    end
    if (adv && s1_vld_q) begin
      out_colour_q <= shade_colour;
      out_bad_q    <= shade_bad;
      out_last_q   <= s1_last_q;
    end
  end

  cpr_shade u_shade (
    .cfg_i    (cfg),
    .entry_i  (s1_entry),
    .mode_i   (s1_mode_q),
    .colour_o (shade_colour),
    .bad_o    (shade_bad)
  );

  assign res_o.valid         = out_vld_q;
  assign res_o.pixel_colour  = out_colour_q;
  assign res_o.bad_index     = out_bad_q;
  assign res_o.line_last_out = out_last_q;

  // a bad index always comes out black
  `CPR_ASSERT(a_bad_black, clk_i, rst_ni, (out_vld_q && out_bad_q) |-> (out_colour_q == '0), "bad index result has nonzero colour")
  // write items never reach the read stage
  `CPR_ASSERT(a_write_no_result, clk_i, rst_ni, (in_acc && !is_pixel) |=> !s1_vld_q, "write item entered the read stage")
  // every accepted pixel occupies the read stage next cycle
  `CPR_ASSERT(a_pixel_enters, clk_i, rst_ni, (in_acc && is_pixel) |=> s1_vld_q, "pixel item lost before read stage")
  // a result appears only behind a pixel in the read stage
  `CPR_ASSERT(a_result_source, clk_i, rst_ni, $rose(out_vld_q) |-> $past(s1_vld_q), "result without a pixel in flight")

endmodule

// ===== dv/tb_top.sv =====
// ---------------------------------------------------------------------------
// cram palette to rgb testbench
// drives write and pixel items with random gaps and output stalls, predicts
// every packed colour from a local copy of the palette and the field
// positions, and compares each result in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import cpr_pkg::*;

  // spare register slot, writes there must not disturb anything
  localparam logic [1:0] REG_SPARE = 2'd3;

  typedef struct {
    op_e         op;
    logic [5:0]  entry;
    logic [15:0] word;
    logic [7:0]  pix;
    logic        last;
  } pal_item_t;

  typedef struct {
    logic [15:0] colour;
    logic        bad;
    logic        last;
  } pal_colour_t;

  logic clk_i;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  cpr_in_if  pix_if ();
  cpr_out_if res_if ();

  cram_palette_to_rgb u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // items waiting to be driven, and colours waiting to come out
  pal_item_t   pending_items[$];
  pal_colour_t colour_expect[$];

  // local copy of the palette (blue 8:6, green 5:3, red 2:0) and positions
  logic [8:0] palette_shadow [STORE_DEPTH];
  cfg_t       pos_shadow;

  // driver handshake and stall state (in_fire set by the monitor) and the mismatch count
  bit          in_fire;
  bit          in_busy;
  bit          in_calm;
  int unsigned in_gap;
  bit          out_calm;
  int unsigned out_stall;
  int unsigned mismatches;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned rand_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // 3-bit component to its 5-bit shaded level
  function automatic int unsigned level_of(logic [2:0] c, mode_e m);
    case (m)
      MODE_NORMAL:    return 4 * c;
      MODE_HIGHLIGHT: return 16 + 2 * c;
      default:        return 2 * c;
    endcase
  endfunction

  function automatic pal_colour_t predict_colour(pal_item_t it);
    pal_colour_t res;
    mode_e       m;
    logic [8:0]  e;
    logic [31:0] acc;
    m = mode_e'(it.pix[7:6]);
    res.last = it.last;
    if (m == MODE_BAD) begin
      res.colour = '0;
      res.bad    = 1'b1;
    end else begin
      e   = palette_shadow[it.pix[5:0]];
      acc = (32'(level_of(e[2:0], m)) << pos_shadow.red_pos)
          | (32'(level_of(e[5:3], m)) << pos_shadow.green_pos)
          | (32'(level_of(e[8:6], m)) << pos_shadow.blue_pos);
      // anything shifted past bit 15 is simply lost
      res.colour = acc[15:0];
      res.bad    = 1'b0;
    end
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // monitor: input acceptance updates the palette copy or queues a colour,
  // output acceptance is checked against the oldest queued colour
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    pal_item_t   it;
    pal_colour_t want;
    if (rst_ni) begin
      if (pix_if.valid && pix_if.ready) begin
        in_fire  = 1'b1;
        it.op    = op_e'(pix_if.opcode);
        it.entry = pix_if.entry_number;
        it.word  = pix_if.colour_word;
        it.pix   = pix_if.pixel_index;
        it.last  = pix_if.line_last;
        if (it.op == OP_WRITE) begin
          // only bits 11:9, 7:5 and 3:1 of the console word are kept
          palette_shadow[it.entry] = {it.word[11:9], it.word[7:5], it.word[3:1]};
        end else begin
          colour_expect.push_back(predict_colour(it));
        end
      end
      if (res_if.valid && res_if.ready) begin
        if (colour_expect.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t unexpected result colour=%h bad=%b last=%b", $realtime,
                     res_if.pixel_colour, res_if.bad_index, res_if.line_last_out);
        end else begin
          want = colour_expect.pop_front();
          if (res_if.pixel_colour !== want.colour || res_if.bad_index !== want.bad ||
              res_if.line_last_out !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%t mismatch exp colour=%h bad=%b last=%b got colour=%h bad=%b last=%b",
                       $realtime, want.colour, want.bad, want.last, res_if.pixel_colour,
                       res_if.bad_index, res_if.line_last_out);
          end
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // driver: presents pending items with random gaps, and stalls the output
  // with random ready drops; calm stretches run with no idling at all
  // -------------------------------------------------------------------------
  always @(negedge clk_i) begin : driver
    pal_item_t nxt;
    if (rst_ni) begin
      if (in_fire || !in_busy) begin
        in_fire = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
          in_busy = 1'b0;
          pix_if.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          nxt = pending_items.pop_front();
          pix_if.opcode       <= nxt.op;
          pix_if.entry_number <= nxt.entry;
          pix_if.colour_word  <= nxt.word;
          pix_if.pixel_index  <= nxt.pix;
          pix_if.line_last    <= nxt.last;
          pix_if.valid        <= 1'b1;
          in_busy = 1'b1;
          if ($urandom_range(0, 49) == 0) in_calm = !in_calm;
          in_gap = in_calm ? 0 : rand_gap();
        end else begin
          in_busy = 1'b0;
          pix_if.valid <= 1'b0;
        end
      end
      if ($urandom_range(0, 99) == 0) out_calm = !out_calm;
      if (out_stall > 0) begin
        out_stall--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
        if (!out_calm && $urandom_range(0, 3) == 0) out_stall = rand_gap();
      end
    end
  end

  task automatic push_write(logic [5:0] entry, logic [15:0] word);
    pal_item_t it;
    it.op    = OP_WRITE;
    it.entry = entry;
    it.word  = word;
    // pixel fields are don't-care for a write, keep them busy anyway
    it.pix   = 8'($urandom());
    it.last  = 1'($urandom());
    pending_items.push_back(it);
  endtask

  task automatic push_pixel(logic [7:0] pix, logic last);
    pal_item_t it;
    it.op    = OP_PIXEL;
    it.entry = 6'($urandom());
    it.word  = 16'($urandom());
    it.pix   = pix;
    it.last  = last;
    pending_items.push_back(it);
  endtask

  // register write: setup cycle, then access cycle until pready
  task automatic reg_write(logic [1:0] idx, logic [3:0] pos);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {28'($urandom()), pos};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_RED:   pos_shadow.red_pos   = pos;
      REG_GREEN: pos_shadow.green_pos = pos;
      REG_BLUE:  pos_shadow.blue_pos  = pos;
      default:   ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_positions(logic [3:0] r, logic [3:0] g, logic [3:0] b);
    reg_write(REG_RED, r);
    reg_write(REG_GREEN, g);
    reg_write(REG_BLUE, b);
    if ($urandom_range(0, 1) == 1) reg_write(REG_SPARE, 4'($urandom()));
  endtask

  // wait until every item is in and every colour is out, then let the
  // two-stage pipe settle so trailing writes have landed
  task automatic drain();
    while (pending_items.size() != 0 || in_busy || colour_expect.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic random_items(int unsigned count);
    int unsigned p;
    logic [1:0]  m;
    repeat (count) begin
      if ($urandom_range(0, 99) < 30) begin
        push_write(6'($urandom()), 16'($urandom()));
      end else begin
        p = $urandom_range(0, 99);
        m = (p < 30) ? MODE_NORMAL : (p < 60) ? MODE_HIGHLIGHT :
            (p < 92) ? MODE_SHADOW : MODE_BAD;
        push_pixel({m, 6'($urandom())}, ($urandom_range(0, 7) == 0));
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // stimulus: directed corners first, then random phases with the field
  // positions changed in between while the block is idle
  // -------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned ph;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    pix_if.valid = 1'b0;
    pix_if.opcode       = OP_WRITE;
    pix_if.entry_number = '0;
    pix_if.colour_word  = '0;
    pix_if.pixel_index  = '0;
    pix_if.line_last    = 1'b0;
    res_if.ready = 1'b0;
    in_fire   = 1'b0;
    in_busy   = 1'b0;
    in_calm   = 1'b0;
    in_gap    = 0;
    out_calm  = 1'b0;
    out_stall = 0;
    mismatches = 0;
    for (int i = 0; i < STORE_DEPTH; i++) palette_shadow[i] = '0;
    pos_shadow.red_pos   = RED_POS_RST;
    pos_shadow.green_pos = GREEN_POS_RST;
    pos_shadow.blue_pos  = BLUE_POS_RST;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, reset positions
    push_pixel({MODE_NORMAL, 6'd5}, 1'b0);      // never-written entry reads zero
    push_pixel({MODE_HIGHLIGHT, 6'd5}, 1'b1);
    push_write(6'd0, 16'hFFFF);                 // unused word bits set
    push_pixel({MODE_NORMAL, 6'd0}, 1'b0);      // right behind its write
    push_pixel({MODE_HIGHLIGHT, 6'd0}, 1'b0);
    push_pixel({MODE_SHADOW, 6'd0}, 1'b1);
    push_write(6'd63, 16'h0EEE);
    push_pixel({MODE_NORMAL, 6'd63}, 1'b0);
    push_pixel({MODE_SHADOW, 6'd63}, 1'b0);
    push_write(6'd1, 16'hF111);                 // only unused bits set
    push_pixel({MODE_HIGHLIGHT, 6'd1}, 1'b0);
    push_pixel(8'd192, 1'b0);                   // bad mode, low end
    push_pixel(8'd255, 1'b1);                   // bad mode, high end
    push_write(6'd42, 16'h0A42);
    push_pixel({MODE_NORMAL, 6'd42}, 1'b1);
    push_pixel({MODE_HIGHLIGHT, 6'd42}, 1'b0);
    drain();

    // overlapping and large positions on the same entries
    load_positions(4'd0, 4'd0, 4'd0);
    push_pixel({MODE_NORMAL, 6'd42}, 1'b0);
    push_pixel({MODE_HIGHLIGHT, 6'd63}, 1'b1);
    drain();
    load_positions(4'd15, 4'd14, 4'd12);
    push_pixel({MODE_NORMAL, 6'd0}, 1'b0);
    push_pixel({MODE_HIGHLIGHT, 6'd0}, 1'b0);
    push_pixel({MODE_SHADOW, 6'd63}, 1'b1);
    drain();

    // random phases, fixed corner settings first, then free ones
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       load_positions(4'd10, 4'd5, 4'd0);
        1:       load_positions(4'd0, 4'd0, 4'd0);
        2:       load_positions(4'd11, 4'd11, 4'd11);
        3:       load_positions(4'd15, 4'd14, 4'd12);
        4:       load_positions(4'd0, 4'd11, 4'd6);
        default: load_positions(4'($urandom()), 4'($urandom()), 4'($urandom()));
      endcase
      random_items(150);
      drain();
    end

    mismatches += colour_expect.size();
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // run limit, far above the slowest legal run
  initial begin : watchdog
    #20000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
